// ----- hw/rtl/pfje_pkg.sv -----
`timescale 1ns / 1ps
package pfje_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int CORDIC_STEPS = 30;

  // angle difference scaled to signed q9.30 and its magnitude
  localparam int ANG_SHIFT = 30 - FRAC_BITS;
  localparam int MAG_W     = 63 - FRAC_BITS;
  localparam int CMP_W     = MAG_W + 1;
  localparam int MOD_STEPS = 31 - FRAC_BITS;

  // cordic word, products and saturation input
  localparam int CW   = 34;
  localparam int PW   = CW + 32;
  localparam int SATW = 68;

  // register stages ahead of the output buffer
  localparam int NST = MOD_STEPS + 38;

  localparam logic [33:0]           TWO_PI_Q30  = 34'd6746518852;
  localparam logic signed [34:0]    TWO_PI_S    = 35'sd6746518852;
  localparam logic signed [34:0]    PI_S        = 35'sd3373259426;
  localparam logic signed [34:0]    HALF_PI_S   = 35'sd1686629713;
  localparam logic signed [CW-1:0]  CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               diag;
    logic               present;
    logic signed [31:0] vv;
    logic signed [31:0] g;
    logic signed [31:0] b;
    logic signed [31:0] p;
    logic signed [31:0] q;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] res;
    if (v[SATW-1:31] == {(SATW-31){v[SATW-1]}}) begin
      res = v[31:0];
    end else if (v[SATW-1]) begin
      res = 32'sh80000000;
    end else begin
      res = 32'sh7fffffff;
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] res;
    case (idx)
      5'd0:  res = 34'sh3243F6A8;
      5'd1:  res = 34'sh1DAC6705;
      5'd2:  res = 34'sh0FADBAFC;
      5'd3:  res = 34'sh07F56EA6;
      5'd4:  res = 34'sh03FEAB76;
      5'd5:  res = 34'sh01FFD55B;
      5'd6:  res = 34'sh00FFFAAA;
      5'd7:  res = 34'sh007FFF55;
      5'd8:  res = 34'sh003FFFEA;
      5'd9:  res = 34'sh001FFFFD;
      5'd10: res = 34'sh000FFFFF;
      5'd11: res = 34'sh0007FFFF;
      5'd12: res = 34'sh0003FFFF;
      5'd13: res = 34'sh0001FFFF;
      5'd14: res = 34'sh0000FFFF;
      5'd15: res = 34'sh00007FFF;
      5'd16: res = 34'sh00003FFF;
      5'd17: res = 34'sh00001FFF;
      5'd18: res = 34'sh00000FFF;
      5'd19: res = 34'sh000007FF;
      5'd20: res = 34'sh000003FF;
      5'd21: res = 34'sh000001FF;
      5'd22: res = 34'sh000000FF;
      5'd23: res = 34'sh0000007F;
      5'd24: res = 34'sh0000003F;
      5'd25: res = 34'sh0000001F;
      5'd26: res = 34'sh0000000F;
      5'd27: res = 34'sh00000007;
      5'd28: res = 34'sh00000003;
      5'd29: res = 34'sh00000001;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ----- hw/rtl/power_flow_jacobian_element.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: vk, vj, angles, g, b, p, q; tuser: diag
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: j1, j2, j3, j4; tuser: present
//
// one item per cycle unless the output buffer holds the pipeline; the path runs through
// the angle reduction stages (one quotient bit each) and the 30 cordic stages
// rst is synchronous and clears the pipeline valid flags and the output buffer
// a two-entry output buffer lets items enter while a result waits; the pipeline
// holds only when both entries are full
module power_flow_jacobian_element (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // volt_row, volt_col, angle_row, angle_col, conductance, susceptance,
  // power_active, power_reactive (32 bits each)
  input  logic [255:0] s_axis_tdata,
  // is_diagonal
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dp_dangle, dp_dvolt, dq_dangle, dq_dvolt (32 bits each)
  output logic [127:0] m_axis_tdata,
  // present
  output logic [0:0]   m_axis_tuser
);

  localparam int F        = pfje_pkg::FRAC_BITS;
  localparam int MW       = pfje_pkg::MAG_W;
  localparam int CMPW     = pfje_pkg::CMP_W;
  localparam int MSTEPS   = pfje_pkg::MOD_STEPS;
  localparam int CSTEPS   = pfje_pkg::CORDIC_STEPS;
  localparam int CW       = pfje_pkg::CW;
  localparam int PW       = pfje_pkg::PW;
  localparam int SATW     = pfje_pkg::SATW;
  localparam int NST      = pfje_pkg::NST;
  localparam int ST_FLIP  = MSTEPS + 34;
  localparam int ST_PROD  = ST_FLIP + 1;
  localparam int ST_COMB  = ST_PROD + 1;
  localparam int ST_PROD2 = ST_COMB + 1;

  logic adv;
  logic [NST-1:0] vld;

  logic signed [31:0] in_vk, in_vj, in_ak, in_aj, in_g, in_b, in_p, in_q;
  logic in_diag;

  assign in_vk   = s_axis_tdata[31:0];
  assign in_vj   = s_axis_tdata[63:32];
  assign in_ak   = s_axis_tdata[95:64];
  assign in_aj   = s_axis_tdata[127:96];
  assign in_g    = s_axis_tdata[159:128];
  assign in_b    = s_axis_tdata[191:160];
  assign in_p    = s_axis_tdata[223:192];
  assign in_q    = s_axis_tdata[255:224];
  assign in_diag = s_axis_tuser[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // side fields that ride along the pipeline
  pfje_pkg::side_t side [NST];
  pfje_pkg::side_t side0_next, side1_next;

  always_comb begin
    side0_next.diag    = in_diag;
    side0_next.present = in_diag | (in_g != 32'sd0) | (in_b != 32'sd0);
    side0_next.vv      = '0;
    side0_next.g       = in_g;
    side0_next.b       = in_b;
    side0_next.p       = in_p;
    side0_next.q       = in_q;
  end

  // stage 0: voltage product, scaled angle difference
  logic signed [63:0]   prod0, prod0_next;
  logic signed [MW-1:0] r0, r0_next;
  logic signed [31:0]   vop;

  assign vop        = in_diag ? in_vk : in_vj;
  assign prod0_next = in_vk * vop;
  assign r0_next    = (MW'(in_ak) - MW'(in_aj)) <<< pfje_pkg::ANG_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side0_next;
      prod0   <= prod0_next;
      r0      <= r0_next;
    end
  end

  // stage 1: scale product, magnitude of angle
  logic [MW-1:0] mag [MSTEPS+1];
  logic          neg [MSTEPS+1];

  always_comb begin
    side1_next    = side[0];
    side1_next.vv = pfje_pkg::sat32(SATW'(prod0 >>> F));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= side1_next;
      mag[0]  <= r0[MW-1] ? MW'(-r0) : MW'(r0);
      neg[0]  <= r0[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 2; i < NST; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // restoring reduction modulo 2 pi, one quotient bit a stage
  for (genvar k = 0; k < MSTEPS; k++) begin : g_mod
    localparam logic [CMPW-1:0] MODK = CMPW'(pfje_pkg::TWO_PI_Q30) << (MSTEPS - 1 - k);
    logic [CMPW-1:0] ext;
    logic            ge;

    assign ext = CMPW'(mag[k]);
    assign ge  = ext >= MODK;

    always_ff @(posedge clk) begin
      if (adv) begin
        mag[k+1] <= ge ? MW'(ext - MODK) : mag[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  // wrap into [-pi, pi]
  logic signed [34:0] rem_s, wrap_next, wrap;

  always_comb begin
    rem_s = $signed({2'b00, mag[MSTEPS][32:0]});
    if (neg[MSTEPS]) begin
      rem_s = -rem_s;
    end
    wrap_next = rem_s;
    if (rem_s > pfje_pkg::PI_S) begin
      wrap_next = rem_s - pfje_pkg::TWO_PI_S;
    end else if (rem_s < -pfje_pkg::PI_S) begin
      wrap_next = rem_s + pfje_pkg::TWO_PI_S;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wrap <= wrap_next;
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [CW-1:0] cx [CSTEPS+1];
  logic signed [CW-1:0] cy [CSTEPS+1];
  logic signed [CW-1:0] cz [CSTEPS+1];
  logic                 flip [CSTEPS+1];
  logic signed [34:0]   fold_next;
  logic                 flip_next;

  always_comb begin
    fold_next = wrap;
    flip_next = 1'b0;
    if (wrap > pfje_pkg::HALF_PI_S) begin
      fold_next = wrap - pfje_pkg::PI_S;
      flip_next = 1'b1;
    end else if (wrap < -pfje_pkg::HALF_PI_S) begin
      fold_next = wrap + pfje_pkg::PI_S;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]   <= pfje_pkg::CORDIC_GAIN;
      cy[0]   <= '0;
      cz[0]   <= CW'(fold_next);
      flip[0] <= flip_next;
    end
  end

  // rotation cordic, one micro-rotation a stage
  for (genvar i = 0; i < CSTEPS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN = pfje_pkg::atan_q30(5'(i));
    logic signed [CW-1:0] xs, ys;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][CW-1]) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATAN;
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // undo the fold
  logic signed [CW-1:0] sin_v, cos_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_v <= flip[CSTEPS] ? -cy[CSTEPS] : cy[CSTEPS];
      cos_v <= flip[CSTEPS] ? -cx[CSTEPS] : cx[CSTEPS];
    end
  end

  // admittance products
  logic signed [CW-1:0] opa, opb;
  logic signed [PW-1:0] pa, pb, pc, pd;

  assign opa = side[ST_FLIP].diag ? CW'(side[ST_FLIP].vv) : sin_v;
  assign opb = side[ST_FLIP].diag ? CW'(side[ST_FLIP].vv) : cos_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= side[ST_FLIP].g * opa;
      pb <= side[ST_FLIP].b * opb;
      pc <= side[ST_FLIP].g * cos_v;
      pd <= side[ST_FLIP].b * sin_v;
    end
  end

  // combine: t1, t2 off the diagonal, g v^2 and b v^2 on it
  logic signed [PW:0]  psub, padd;
  logic signed [31:0]  e1, e2;

  assign psub = (PW+1)'(pa) - (PW+1)'(pb);
  assign padd = (PW+1)'(pc) + (PW+1)'(pd);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side[ST_PROD].diag) begin
        e1 <= pfje_pkg::sat32(SATW'(pa >>> F));
        e2 <= pfje_pkg::sat32(SATW'(pb >>> F));
      end else begin
        e1 <= pfje_pkg::sat32(SATW'(psub >>> 30));
        e2 <= pfje_pkg::sat32(SATW'(padd >>> 30));
      end
    end
  end

  // voltage scaling and diagonal sums
  logic signed [63:0] m1, m2;
  logic signed [31:0] dj1, dj2, dj3, dj4;
  logic signed [33:0] s1, s2, s3, s4;

  assign s1 = -34'(side[ST_COMB].q) - 34'(e2);
  assign s2 = 34'(side[ST_COMB].p) + 34'(e1);
  assign s3 = 34'(side[ST_COMB].p) - 34'(e1);
  assign s4 = 34'(side[ST_COMB].q) - 34'(e2);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= side[ST_COMB].vv * e1;
      m2  <= side[ST_COMB].vv * e2;
      dj1 <= pfje_pkg::sat32(SATW'(s1));
      dj2 <= pfje_pkg::sat32(SATW'(s2));
      dj3 <= pfje_pkg::sat32(SATW'(s3));
      dj4 <= pfje_pkg::sat32(SATW'(s4));
    end
  end

  // final select
  logic signed [31:0] oj1, oj2, oj3;
  logic signed [31:0] fj1, fj2, fj3, fj4;
  logic [127:0]       fin_data;
  logic               fin_user;

  assign oj1 = pfje_pkg::sat32(SATW'(m1 >>> F));
  assign oj2 = pfje_pkg::sat32(SATW'(m2 >>> F));
  assign oj3 = pfje_pkg::sat32(-SATW'(oj2));

  always_comb begin
    if (!side[ST_PROD2].present) begin
      fj1 = '0;
      fj2 = '0;
      fj3 = '0;
      fj4 = '0;
    end else if (side[ST_PROD2].diag) begin
      fj1 = dj1;
      fj2 = dj2;
      fj3 = dj3;
      fj4 = dj4;
    end else begin
      fj1 = oj1;
      fj2 = oj2;
      fj3 = oj3;
      fj4 = oj1;
    end
  end

  assign fin_data = {fj4, fj3, fj2, fj1};
  assign fin_user = side[ST_PROD2].present;

  // output register with skid entry
  logic         out_v, skid_v;
  logic [127:0] out_data, skid_data;
  logic         out_user, skid_user;

  assign adv           = !skid_v;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (m_axis_tready) begin
        skid_v <= 1'b0;
      end
    end else if (!out_v || m_axis_tready) begin
      out_v <= vld[NST-1];
    end else if (vld[NST-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end
    end else if (!out_v || m_axis_tready) begin
      out_data <= fin_data;
      out_user <= fin_user;
    end else begin
      skid_data <= fin_data;
      skid_user <= fin_user;
    end
  end

  assign m_axis_tvalid   = out_v;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_user;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int FB = pfje_pkg::FRAC_BITS;
  localparam int ONE = 1 << FB;
  localparam int PI_FX = 52707179;
  localparam int HALF_PI_FX = 26353589;
  localparam int WMAX = 32'sh7fffffff;
  localparam int WMIN = 32'sh80000000;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam int ROT_STEPS = 30;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_WAIT = 60;

  typedef struct packed {
    logic               is_diagonal;
    logic signed [31:0] volt_row;
    logic signed [31:0] volt_col;
    logic signed [31:0] angle_row;
    logic signed [31:0] angle_col;
    logic signed [31:0] conductance;
    logic signed [31:0] susceptance;
    logic signed [31:0] power_active;
    logic signed [31:0] power_reactive;
  } bus_pair_t;

  typedef struct packed {
    logic signed [31:0] dp_dangle;
    logic signed [31:0] dp_dvolt;
    logic signed [31:0] dq_dangle;
    logic signed [31:0] dq_dvolt;
    logic               present;
  } jac_entry_t;

  typedef struct packed {
    bus_pair_t pair;
    logic      drain_before;
  } queued_pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  queued_pair_t pending_pairs[$];
  jac_entry_t   expected_entries[$];
  queued_pair_t next_slot;
  bus_pair_t    driven_pair;
  jac_entry_t   want;
  jac_entry_t   got;
  bit           pair_taken = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  int           error_count = 0;

  longint atan_step [ROT_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

  power_flow_jacobian_element u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > longint'(WMAX)) return longint'(WMAX);
    if (v < longint'(WMIN)) return longint'(WMIN);
    return v;
  endfunction

  function automatic longint fixmul(longint a, longint b);
    return clamp32((a * b) >>> FB);
  endfunction

  function automatic void unit_phasor(input longint d, output longint s, output longint c);
    longint r;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    r = d * (longint'(1) << (30 - FB));
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    r = r % TWO_PI_Q30;
    if (r > PI_Q30) r -= TWO_PI_Q30;
    else if (r < -PI_Q30) r += TWO_PI_Q30;
    if (r > HALF_PI_Q30) begin
      r -= PI_Q30;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= atan_step[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += atan_step[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic jac_entry_t jacobian_of(bus_pair_t p);
    jac_entry_t e;
    longint vk, vj, g, b, pa, qr;
    longint j1, j2, j3, j4;
    longint v2, gv, bv, s, c, vv, t1, t2;
    vk = longint'(p.volt_row);
    vj = longint'(p.volt_col);
    g = longint'(p.conductance);
    b = longint'(p.susceptance);
    pa = longint'(p.power_active);
    qr = longint'(p.power_reactive);
    j1 = 0;
    j2 = 0;
    j3 = 0;
    j4 = 0;
    e.present = 1'b0;
    if (p.is_diagonal) begin
      v2 = fixmul(vk, vk);
      gv = fixmul(g, v2);
      bv = fixmul(b, v2);
      j1 = clamp32(-qr - bv);
      j2 = clamp32(pa + gv);
      j3 = clamp32(pa - gv);
      j4 = clamp32(qr - bv);
      e.present = 1'b1;
    end else if (g != 0 || b != 0) begin
      unit_phasor(longint'(p.angle_row) - longint'(p.angle_col), s, c);
      vv = fixmul(vk, vj);
      t1 = clamp32((g * s - b * c) >>> 30);
      t2 = clamp32((g * c + b * s) >>> 30);
      j1 = fixmul(vv, t1);
      j2 = fixmul(vv, t2);
      j3 = clamp32(-j2);
      j4 = j1;
      e.present = 1'b1;
    end
    e.dp_dangle = j1[31:0];
    e.dp_dvolt = j2[31:0];
    e.dq_dangle = j3[31:0];
    e.dq_dvolt = j4[31:0];
    return e;
  endfunction

  function automatic int rand_signed(int unsigned half);
    return int'(longint'($urandom_range(2 * half, 0)) - longint'(half));
  endfunction

  function automatic int rand_volt();
    return int'($urandom_range(20132659, 13421773));
  endfunction

  task automatic queue_pair(input bit diag, input int vr, input int vc, input int ar,
                            input int ac, input int g, input int b, input int pa,
                            input int qr, input bit drain);
    queued_pair_t qp;
    qp.pair.is_diagonal = diag;
    qp.pair.volt_row = vr;
    qp.pair.volt_col = vc;
    qp.pair.angle_row = ar;
    qp.pair.angle_col = ac;
    qp.pair.conductance = g;
    qp.pair.susceptance = b;
    qp.pair.power_active = pa;
    qp.pair.power_reactive = qr;
    qp.drain_before = drain;
    pending_pairs.push_back(qp);
  endtask

  task automatic check_word(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      error_count++;
    end
  endtask

  // source side
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pair_taken) begin
      pair_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pairs.size() != 0 &&
                   !(pending_pairs[0].drain_before && expected_entries.size() != 0)) begin
        next_slot = pending_pairs.pop_front();
        driven_pair = next_slot.pair;
        s_axis_tdata <= {driven_pair.power_reactive, driven_pair.power_active,
                         driven_pair.susceptance, driven_pair.conductance,
                         driven_pair.angle_col, driven_pair.angle_row,
                         driven_pair.volt_col, driven_pair.volt_row};
        s_axis_tuser <= driven_pair.is_diagonal;
        s_axis_tvalid <= 1'b1;
        if (pending_pairs.size() >= QUIET_TAIL && $urandom_range(7, 0) == 0) begin
          send_gap = $urandom_range(14, 1);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (pending_pairs.size() >= QUIET_TAIL && $urandom_range(9, 0) == 0) begin
        stall_left = $urandom_range(14, 1);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_entries.size() == 0) begin
          $error("result item with no expected entry waiting");
          error_count++;
        end else begin
          want = expected_entries.pop_front();
          got.dp_dangle = m_axis_tdata[31:0];
          got.dp_dvolt = m_axis_tdata[63:32];
          got.dq_dangle = m_axis_tdata[95:64];
          got.dq_dvolt = m_axis_tdata[127:96];
          got.present = m_axis_tuser[0];
          check_word("dp_dangle", want.dp_dangle, got.dp_dangle);
          check_word("dp_dvolt", want.dp_dvolt, got.dp_dvolt);
          check_word("dq_dangle", want.dq_dangle, got.dq_dangle);
          check_word("dq_dvolt", want.dq_dvolt, got.dq_dvolt);
          check_word("present", {31'b0, want.present}, {31'b0, got.present});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_entries.push_back(jacobian_of(driven_pair));
        pair_taken = 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL power_flow_jacobian_element");
    $finish;
  end

  initial begin
    queued_pair_t qp;
    int kind;
    // diagonal
    queue_pair(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(1, ONE, 12345, 999, -999, ONE / 2, -10 * ONE, ONE, -ONE / 2, 0);
    queue_pair(1, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0);
    queue_pair(1, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0);
    queue_pair(1, WMAX, 0, 0, 0, WMIN, WMAX, WMIN, WMAX, 0);
    queue_pair(1, -ONE, WMIN, WMAX, WMIN, 3 * ONE, 7 * ONE, WMAX, WMIN, 0);
    // unconnected pair
    queue_pair(0, ONE, ONE, 100, 200, 0, 0, WMAX, WMIN, 0);
    queue_pair(0, WMAX, WMIN, WMIN, WMAX, 0, 0, WMAX, WMAX, 0);
    // single admittance part
    queue_pair(0, ONE, ONE, 0, 0, 0, -5 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, ONE / 4, 0, 3 * ONE, 0, 0, 0, 0);
    // widest angle differences
    queue_pair(0, ONE, ONE, WMAX, WMIN, ONE, -ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, WMIN, WMAX, ONE, -ONE, 0, 0, 0);
    // fold and wrap boundaries
    queue_pair(0, ONE, ONE, PI_FX, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, -PI_FX, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, HALF_PI_FX, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, -HALF_PI_FX, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, HALF_PI_FX + 1, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, -HALF_PI_FX - 1, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    queue_pair(0, ONE, ONE, PI_FX + 1, 0, 2 * ONE, -3 * ONE, 0, 0, 0);
    // saturation and extremes off the diagonal, and one ordinary pair
    queue_pair(0, WMAX, WMAX, ONE, 0, WMAX, WMAX, 0, 0, 0);
    queue_pair(0, WMIN, WMAX, 0, ONE, WMIN, WMIN, 0, 0, 0);
    queue_pair(0, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0);
    queue_pair(0, 17112760, 16441672, 1677722, -838861, 41943040, -134217728, 0, 0, 0);

    for (int n = 0; n < 1550; n++) begin
      kind = $urandom_range(99, 0);
      qp.pair.is_diagonal = 1'b0;
      qp.pair.volt_row = $urandom();
      qp.pair.volt_col = $urandom();
      qp.pair.angle_row = $urandom();
      qp.pair.angle_col = $urandom();
      qp.pair.conductance = $urandom();
      qp.pair.susceptance = $urandom();
      qp.pair.power_active = $urandom();
      qp.pair.power_reactive = $urandom();
      qp.drain_before = (n == 400 || n == 900);
      if (kind < 15) begin
        qp.pair.is_diagonal = 1'b1;
        qp.pair.volt_row = rand_volt();
        qp.pair.conductance = rand_signed(1 << 30);
        qp.pair.susceptance = rand_signed(1 << 30);
        qp.pair.power_active = rand_signed(1 << 28);
        qp.pair.power_reactive = rand_signed(1 << 28);
      end else if (kind < 25) begin
        qp.pair.conductance = 0;
        qp.pair.susceptance = 0;
      end else if (kind < 30) begin
        if ($urandom_range(1, 0) == 0) qp.pair.conductance = 0;
        else qp.pair.susceptance = 0;
      end else if (kind < 50) begin
        qp.pair.is_diagonal = 1'($urandom_range(1, 0));
      end else begin
        qp.pair.volt_row = rand_volt();
        qp.pair.volt_col = rand_volt();
        if ($urandom_range(9, 0) == 0) begin
          qp.pair.angle_row = rand_signed(1 << 30);
          qp.pair.angle_col = rand_signed(1 << 30);
        end else begin
          qp.pair.angle_row = rand_signed(ONE);
          qp.pair.angle_col = rand_signed(ONE);
        end
        qp.pair.conductance = rand_signed(1 << 30);
        qp.pair.susceptance = rand_signed(1 << 30);
      end
      pending_pairs.push_back(qp);
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS power_flow_jacobian_element");
    end else begin
      $display("FAIL power_flow_jacobian_element");
    end
    $finish;
  end

endmodule
